// ===== hdl/circular_binomial_blur_2d_macros.svh =====
// Assertion helpers for the blur block checkers.
// Every check samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef CIRCULAR_BINOMIAL_BLUR_2D_MACROS_SVH
`define CIRCULAR_BINOMIAL_BLUR_2D_MACROS_SVH

// Plain property check.
`define CBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The property holds in the cycle after the condition.
`define CBB_ASSERT_NEXT(lbl, cond, prop, msg) \
  `CBB_ASSERT(lbl, (cond) |=> (prop), msg)

`endif

// ===== hdl/cbb_pkg.sv =====
package cbb_pkg;

  // Field widths of the transaction ports.
  localparam int POS_W    = 7;
  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 24;
  localparam int CFG_W    = 8;
  localparam int DIM_W    = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Default sizes of the slice store.
  localparam int DEF_MAX_WIDTH   = 128;
  localparam int DEF_MAX_HEIGHT  = 128;
  localparam int DEF_SAMPLE_BITS = 24;

  // Kernel geometry. The 2D weights sum to 64 * 64 = 4096.
  localparam int TAP_COUNT   = 7;
  localparam int TAP_HALF    = 3;
  localparam int NORM_SHIFT  = 12;
  localparam int ROUND_BIAS  = 2048;
  localparam int PAIR_W      = 9;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register index codes, taken from the word address.
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_ROW_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // One-dimensional binomial weight of a tap.
  function automatic logic [4:0] tap_weight(input logic [2:0] tap);
    logic [4:0] w;
    unique case (tap)
      3'd0:    w = 5'd1;
      3'd1:    w = 5'd6;
      3'd2:    w = 5'd15;
      3'd3:    w = 5'd20;
      3'd4:    w = 5'd15;
      3'd5:    w = 5'd6;
      3'd6:    w = 5'd1;
      default: w = 5'd0;
    endcase
    return w;
  endfunction

  // Separable weight of one tap of the 7x7 window.
  function automatic logic [PAIR_W-1:0] pair_weight(input logic [2:0] tx,
                                                    input logic [2:0] ty);
    logic [9:0] p;
    p = 10'(tap_weight(tx)) * 10'(tap_weight(ty));
    return PAIR_W'(p);
  endfunction

endpackage

// ===== hdl/cbb_ram.sv =====
module cbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/circular_binomial_blur_2d.sv =====
// Circular 7x7 binomial blur over one slice held in a single-port memory.
// A write transaction stores one sample; writes may follow each other in every
// cycle. A query whose position lies inside the configured size reads its 49
// wrapped neighbours from the slice memory, one per cycle, and its result strobe
// follows the last read through the read data, product and result registers;
// busy is high in between, and the next transaction can be accepted in the cycle
// that shows the result. The single memory port and its registered read set that
// pace. A query outside the configured size returns bad_position_o in the next
// cycle with busy staying low. Results appear on result_valid_o for exactly one
// cycle and cannot be held off. The memory is not cleared after reset; every
// sample must be written before a query reads it. Size registers must be written
// only while the block is idle; the block itself does not enforce this.
module circular_binomial_blur_2d
  import cbb_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Transaction port
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode_i,
  input  logic [POS_W-1:0]           pos_x_i,
  input  logic [POS_W-1:0]           pos_y_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  // Results
  output logic                       result_valid_o,
  output logic signed [OUT_W-1:0]    filtered_o,
  output logic                       bad_position_o,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = SAMPLE_BITS + PAIR_W + 1;
  localparam int ACC_W  = SAMPLE_BITS + 13;
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);
  localparam logic [2:0] TAP_LAST = 3'(TAP_COUNT - 1);
  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(ROUND_BIAS);

  // Step one position back or forward with wrap at size n.
  function automatic logic [DIM_W-1:0] wrap_dec(input logic [DIM_W-1:0] s,
                                                input logic [DIM_W-1:0] n);
    return (s == '0) ? n - DIM_W'(1) : s - DIM_W'(1);
  endfunction

  function automatic logic [DIM_W-1:0] wrap_inc(input logic [DIM_W-1:0] s,
                                                input logic [DIM_W-1:0] n);
    return (s == n - DIM_W'(1)) ? '0 : s + DIM_W'(1);
  endfunction

  state_e state_q, state_d;

  logic [CFG_W-1:0] row_length_q, row_count_q;
  logic [DIM_W-1:0] nx, ny;
  logic [DIM_W-1:0] px, py, start_x, start_y;
  logic [DIM_W-1:0] cur_x_q, cur_y_q, start_x_q;
  logic [2:0]       tap_x_q, tap_y_q;
  logic             accept, query_ok, query_bad, write_ok, issue, last_issue;
  logic             cfg_write;

  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  logic                    vld_s1_q, last_s1_q, vld_s2_q, last_s2_q;
  logic [PAIR_W-1:0]       w_s1_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_sum, rounded;
  logic signed [SAMPLE_BITS-1:0] rd_s;
  logic signed [PAIR_W:0]  w_s;

  logic                    result_valid_q, bad_q;
  logic signed [OUT_W-1:0] filtered_q;

  // Effective wrap sizes: zero counts as one, larger than the store clamps.
  always_comb begin
    if (row_length_q == '0) begin
      nx = DIM_W'(1);
    end else if ({5'd0, row_length_q} > MAXW13) begin
      nx = DIM_W'(MAX_WIDTH);
    end else begin
      nx = row_length_q;
    end
    if (row_count_q == '0) begin
      ny = DIM_W'(1);
    end else if ({5'd0, row_count_q} > MAXH13) begin
      ny = DIM_W'(MAX_HEIGHT);
    end else begin
      ny = row_count_q;
    end
  end

  // Transaction decode.
  assign px         = {1'b0, pos_x_i};
  assign py         = {1'b0, pos_y_i};
  assign accept     = start && !busy;
  assign query_ok   = accept && (opcode_i == OP_QUERY) && (px < nx) && (py < ny);
  assign query_bad  = accept && (opcode_i == OP_QUERY) && !((px < nx) && (py < ny));
  assign write_ok   = accept && (opcode_i == OP_WRITE) &&
                      ({6'd0, pos_x_i} < MAXW13) && ({6'd0, pos_y_i} < MAXH13);
  assign start_x    = wrap_dec(wrap_dec(wrap_dec(px, nx), nx), nx);
  assign start_y    = wrap_dec(wrap_dec(wrap_dec(py, ny), ny), ny);
  assign last_issue = (tap_x_q == TAP_LAST) && (tap_y_q == TAP_LAST);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_ok) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (last_s2_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy = 1'b0;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: busy = 1'b1;
      default: begin
        busy  = 1'b1;
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window walk: x steps fastest, each row restarts at the left edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_x_q   <= '0;
      tap_y_q   <= '0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      start_x_q <= '0;
    end else if (query_ok) begin
      tap_x_q   <= '0;
      tap_y_q   <= '0;
      cur_x_q   <= start_x;
      cur_y_q   <= start_y;
      start_x_q <= start_x;
    end else if (issue) begin
      if (tap_x_q == TAP_LAST) begin
        tap_x_q <= '0;
        tap_y_q <= tap_y_q + 3'd1;
        cur_x_q <= start_x_q;
        cur_y_q <= wrap_inc(cur_y_q, ny);
      end else begin
        tap_x_q <= tap_x_q + 3'd1;
        cur_x_q <= wrap_inc(cur_x_q, nx);
      end
    end
  end

  // Memory port: writes while idle, window reads while running.
  always_comb begin
    ram_we    = write_ok;
    ram_wdata = SAMPLE_BITS'(sample_i);
    if (issue) begin
      ram_addr = AW'(32'(cur_y_q) * MAX_WIDTH + 32'(cur_x_q));
    end else begin
      ram_addr = AW'(32'(pos_y_i) * MAX_WIDTH + 32'(pos_x_i));
    end
  end

  cbb_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_slice_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Pipeline control: read issue, data return, product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s1_q  <= 1'b0;
      last_s1_q <= 1'b0;
      vld_s2_q  <= 1'b0;
      last_s2_q <= 1'b0;
    end else begin
      vld_s1_q  <= issue;
      last_s1_q <= issue && last_issue;
      vld_s2_q  <= vld_s1_q;
      last_s2_q <= last_s1_q;
    end
  end

  // Weight times sample, registered before the accumulator.
  assign rd_s   = $signed(ram_rdata);
  assign w_s    = $signed({1'b0, w_s1_q});
  assign prod_d = rd_s * w_s;

  always_ff @(posedge clk_i) begin
    w_s1_q <= pair_weight(tap_x_q, tap_y_q);
    prod_q <= prod_d;
  end

  // Exact accumulation, then round half up by the kernel norm.
  assign acc_sum = acc_q + ACC_W'(prod_q);
  assign rounded = acc_sum + BIAS;

  always_ff @(posedge clk_i) begin
    if (query_ok) begin
      acc_q <= '0;
    end else if (vld_s2_q) begin
      acc_q <= acc_sum;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= query_bad || last_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_bad) begin
      filtered_q <= '0;
      bad_q      <= 1'b1;
    end else if (last_s2_q) begin
      filtered_q <= OUT_W'(rounded >>> NORM_SHIFT);
      bad_q      <= 1'b0;
    end
  end

  assign result_valid_o = result_valid_q;
  assign filtered_o     = filtered_q;
  assign bad_position_o = bad_q;

  // Configuration registers.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= CFG_W'(128);
      row_count_q  <= CFG_W'(128);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ROW_LENGTH: row_length_q <= pwdata[CFG_W-1:0];
        REG_ROW_COUNT:  row_count_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_LENGTH: prdata = {(APB_DW - CFG_W)'(0), row_length_q};
      REG_ROW_COUNT:  prdata = {(APB_DW - CFG_W)'(0), row_count_q};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hdl/cbb_checker.sv =====
`include "circular_binomial_blur_2d_macros.svh"

module cbb_checker
  import cbb_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    opcode_i,
  input logic                    result_valid_o,
  input logic signed [OUT_W-1:0] filtered_o,
  input logic                    bad_position_o
);

  logic take_write, take_query;

  assign take_write = start && !busy && (opcode_i == OP_WRITE);
  assign take_query = start && !busy && (opcode_i == OP_QUERY);

  // A position outside the size reports zero.
  `CBB_ASSERT(a_bad_is_zero, (result_valid_o && bad_position_o) |-> (filtered_o == '0), "bad position with nonzero value")

  // A write produces no result and leaves the block idle.
  `CBB_ASSERT_NEXT(a_write_silent, take_write, (!result_valid_o && !busy), "write produced a result or busy")

  // A query either reports a bad position at once or starts the window walk.
  `CBB_ASSERT_NEXT(a_query_answered, take_query, ((result_valid_o && bad_position_o) || busy), "query neither rejected nor started")

  // The end of a window walk shows a valid filtered result.
  `CBB_ASSERT(a_done_shows_result, $fell(busy) |-> (result_valid_o && !bad_position_o), "walk ended without a result")

  // No result appears in the first cycle of a walk.
  `CBB_ASSERT(a_start_quiet, $rose(busy) |-> !result_valid_o, "result at start of walk")

endmodule

bind circular_binomial_blur_2d cbb_checker u_cbb_checker (.*);

// ===== tb/sv/circular_binomial_blur_2d_tb.sv =====
`timescale 1ns / 1ps

module circular_binomial_blur_2d_tb;
  import cbb_pkg::*;

  localparam int STORE_W = DEF_MAX_WIDTH;
  localparam int STORE_H = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT = 4000;
  localparam longint BINOMIAL_TAP [TAP_COUNT] = '{1, 6, 15, 20, 15, 6, 1};

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    bad_position;
  } blur_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic                       opcode_i;
  logic [POS_W-1:0]           pos_x_i;
  logic [POS_W-1:0]           pos_y_i;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       result_valid_o;
  logic signed [OUT_W-1:0]    filtered_o;
  logic                       bad_position_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  // Local copy of the slice and of the size registers.
  logic signed [SAMPLE_W-1:0] slice_mem [STORE_W*STORE_H];
  bit                         sample_written [STORE_W*STORE_H];
  logic [CFG_W-1:0]           row_length_cfg;
  logic [CFG_W-1:0]           row_count_cfg;

  blur_result_t pending_results [$];
  blur_result_t want_result;
  int           fail_count;
  int           idle_pct;
  int           quiet_cycles;

  circular_binomial_blur_2d dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .filtered_o     (filtered_o),
    .bad_position_o (bad_position_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Free-running clock.
  always #4 clk_i = ~clk_i;

  // Size actually used for a register value: zero acts as one, the store size caps it.
  function automatic int eff_size(input logic [CFG_W-1:0] value, input int limit);
    if (value == 0) return 1;
    if (int'(value) > limit) return limit;
    return int'(value);
  endfunction

  // Filtered value at one position under the current sizes.
  function automatic blur_result_t blur_at(input int x, input int y);
    blur_result_t res;
    longint acc;
    longint row_acc;
    int nx, ny, tx, ty, xx, yy;
    nx = eff_size(row_length_cfg, STORE_W);
    ny = eff_size(row_count_cfg, STORE_H);
    res.filtered = '0;
    res.bad_position = 1'b1;
    if (x >= nx || y >= ny) return res;
    acc = 0;
    for (ty = 0; ty < TAP_COUNT; ty++) begin
      yy = (y + ty + 4 * ny - TAP_HALF) % ny;
      row_acc = 0;
      for (tx = 0; tx < TAP_COUNT; tx++) begin
        xx = (x + tx + 4 * nx - TAP_HALF) % nx;
        row_acc += BINOMIAL_TAP[tx] * longint'(slice_mem[yy * STORE_W + xx]);
      end
      acc += BINOMIAL_TAP[ty] * row_acc;
    end
    res.filtered = OUT_W'((acc + ROUND_BIAS) >>> NORM_SHIFT);
    res.bad_position = 1'b0;
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'hFFFFFF;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Send one transaction and record what it should do once it is accepted.
  task automatic send_item(input logic op, input int x, input int y,
                           input logic [SAMPLE_W-1:0] smp);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start    <= 1'b1;
    opcode_i <= op;
    pos_x_i  <= POS_W'(x);
    pos_y_i  <= POS_W'(y);
    sample_i <= smp;
    do @(posedge clk_i); while (busy);
    if (op == OP_WRITE) begin
      slice_mem[y * STORE_W + x] = smp;
      sample_written[y * STORE_W + x] = 1'b1;
    end else begin
      pending_results.push_back(blur_at(x, y));
    end
  endtask

  // Write every sample of the wrapped window that has never been written.
  task automatic fill_window(input int x, input int y);
    int nx, ny, tx, ty, xx, yy;
    nx = eff_size(row_length_cfg, STORE_W);
    ny = eff_size(row_count_cfg, STORE_H);
    for (ty = 0; ty < TAP_COUNT; ty++) begin
      for (tx = 0; tx < TAP_COUNT; tx++) begin
        yy = (y + ty + 4 * ny - TAP_HALF) % ny;
        xx = (x + tx + 4 * nx - TAP_HALF) % nx;
        if (!sample_written[yy * STORE_W + xx]) send_item(OP_WRITE, xx, yy, rand_sample());
      end
    end
  endtask

  // Query a position, writing its window first when it lies inside the size.
  task automatic query_at(input int x, input int y);
    if (x < eff_size(row_length_cfg, STORE_W) && y < eff_size(row_count_cfg, STORE_H))
      fill_window(x, y);
    send_item(OP_QUERY, x, y, SAMPLE_W'($urandom()));
  endtask

  // Drop start and hold off until every outstanding result has come.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic apb_write(input logic idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_ROW_LENGTH) row_length_cfg = value[CFG_W-1:0];
    else row_count_cfg = value[CFG_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic idx);
    logic [CFG_W-1:0] want;
    want = (idx == REG_ROW_LENGTH) ? row_length_cfg : row_count_cfg;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== want) begin
      $display("%0t register %0d readback: expected %0d actual %0d",
               $time, idx, want, prdata[CFG_W-1:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Size registers change only while the block is idle.
  task automatic set_sizes(input int len, input int cnt);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_write(REG_ROW_LENGTH, APB_DW'(len));
    apb_write(REG_ROW_COUNT, APB_DW'(cnt));
  endtask

  task automatic test_register_access();
    set_sizes(7, 5);
    apb_read_check(REG_ROW_LENGTH);
    apb_read_check(REG_ROW_COUNT);
    set_sizes(255, 0);
    apb_read_check(REG_ROW_LENGTH);
    apb_read_check(REG_ROW_COUNT);
  endtask

  // A one-sample slice returns the sample itself, extremes included.
  task automatic test_unit_slice();
    set_sizes(1, 1);
    send_item(OP_WRITE, 0, 0, 24'h7FFFFF);
    query_at(0, 0);
    send_item(OP_WRITE, 0, 0, 24'h800000);
    query_at(0, 0);
    send_item(OP_WRITE, 0, 0, 24'h000000);
    query_at(0, 0);
  endtask

  // Two columns give a weight of 2048 each, so odd sums land exactly on half.
  task automatic test_rounding_ties();
    set_sizes(2, 1);
    send_item(OP_WRITE, 0, 0, 24'h000000);
    send_item(OP_WRITE, 1, 0, 24'hFFFFFF);
    query_at(0, 0);
    query_at(1, 0);
    send_item(OP_WRITE, 0, 0, 24'hFFFFFE);
    query_at(0, 0);
    send_item(OP_WRITE, 0, 0, 24'h000001);
    send_item(OP_WRITE, 1, 0, 24'h000000);
    query_at(1, 0);
  endtask

  task automatic test_outside_size();
    set_sizes(3, 2);
    query_at(2, 1);
    query_at(3, 0);
    query_at(0, 2);
    query_at(127, 127);
    send_item(OP_WRITE, 127, 127, 24'h7FFFFF);
  endtask

  // Zero sizes act as one; sizes above the store act as the full store.
  task automatic test_clamped_sizes();
    set_sizes(0, 0);
    query_at(0, 0);
    query_at(1, 0);
    query_at(0, 1);
    set_sizes(255, 200);
    query_at(127, 127);
    query_at(0, 0);
  endtask

  // Mostly queries inside the size on a filled window, plus stray queries and writes.
  task automatic test_random_traffic(input int len, input int cnt, input int items,
                                     input int idle);
    int n, kind, x, y, nx, ny;
    set_sizes(len, cnt);
    idle_pct = idle;
    nx = eff_size(row_length_cfg, STORE_W);
    ny = eff_size(row_count_cfg, STORE_H);
    for (n = 0; n < items; n++) begin
      kind = $urandom_range(99);
      if (kind < 3) drain_results();
      if (kind < 60) begin
        x = $urandom_range(nx - 1);
        y = $urandom_range(ny - 1);
        query_at(x, y);
      end else if (kind < 72) begin
        query_at($urandom_range(STORE_W - 1), $urandom_range(STORE_H - 1));
      end else if (kind < 88) begin
        send_item(OP_WRITE, $urandom_range(nx - 1), $urandom_range(ny - 1), rand_sample());
      end else begin
        send_item(OP_WRITE, $urandom_range(STORE_W - 1), $urandom_range(STORE_H - 1),
                  rand_sample());
      end
    end
    idle_pct = 0;
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual filtered %0d bad %0b",
                 $time, filtered_o, bad_position_o);
        fail_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (filtered_o !== want_result.filtered) begin
          $display("%0t filtered: expected %0d actual %0d",
                   $time, want_result.filtered, filtered_o);
          fail_count++;
        end
        if (bad_position_o !== want_result.bad_position) begin
          $display("%0t bad_position: expected %0b actual %0b",
                   $time, want_result.bad_position, bad_position_o);
          fail_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t timeout: %0d results outstanding", $time, pending_results.size());
      $display("FAIL circular_binomial_blur_2d");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    opcode_i       = OP_WRITE;
    pos_x_i        = '0;
    pos_y_i        = '0;
    sample_i       = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fail_count     = 0;
    idle_pct       = 0;
    quiet_cycles   = 0;
    row_length_cfg = CFG_W'(DEF_MAX_WIDTH);
    row_count_cfg  = CFG_W'(DEF_MAX_HEIGHT);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_unit_slice();
    test_rounding_ties();
    test_outside_size();
    test_clamped_sizes();
    test_random_traffic(128, 128, 6, 0);
    test_random_traffic($urandom_range(12, 1), $urandom_range(12, 1), 120, 58);
    test_random_traffic(1, 128, 60, 32);
    test_random_traffic(128, 1, 60, 0);
    test_random_traffic($urandom_range(20), $urandom_range(20), 80, 32);
    test_random_traffic(200, 3, 30, 58);
    test_random_traffic($urandom_range(128, 1), $urandom_range(6, 1), 60, 0);

    // Let the last results and any stray strobe arrive.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS circular_binomial_blur_2d");
    end else begin
      $display("FAIL circular_binomial_blur_2d");
    end
    $finish;
  end

endmodule

// ===== circular_binomial_blur_2d.f =====
+incdir+hdl
hdl/cbb_pkg.sv
hdl/cbb_ram.sv
hdl/circular_binomial_blur_2d.sv
hdl/cbb_checker.sv
tb/sv/circular_binomial_blur_2d_tb.sv
